// ----- src/palette_rle_pixel_encoder_macros.svh -----
// Assertion macros for the palette run-length encoder.
// Needs clk and rst in the scope where a macro is used.
`ifndef PALETTE_RLE_PIXEL_ENCODER_MACROS_SVH
`define PALETTE_RLE_PIXEL_ENCODER_MACROS_SVH

// same-cycle implication
`define PRLE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRLE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/prle_pkg.sv -----
// Shared types and constants for the palette run-length encoder.
// No dependencies.
package prle_pkg;

  localparam int RGB_W     = 24;
  localparam int IDX_OUT_W = 8;
  localparam int CNT_OUT_W = 13;
  localparam int COL_W     = 8;
  localparam int OUT_DW    = 48;
  localparam int OUT_PAD_W = OUT_DW - IDX_OUT_W - 3 * COL_W - CNT_OUT_W;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic search;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
    logic pending;
    logic out_free;
  } status_t;

endpackage

// ----- src/prle_ctrl.sv -----
// Sequencer for the palette run-length encoder: accept, search, emit.
// Depends on prle_pkg.
module prle_ctrl
  import prle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (st.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!st.pending) begin
          state_next = ST_IDLE;
        end else begin
          cmd.emit = st.out_free;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/prle_dp.sv -----
// Datapath: palette memory, search pointer, run state, pending results
// and the output word register. Depends on prle_pkg.
module prle_dp
  import prle_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic [RGB_W-1:0]  in_rgb,
  input  logic              in_row_end,
  input  logic              in_image_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_DW-1:0] out_data,
  output logic              out_last,
  output logic [1:0]        out_kind
);

  localparam int IW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int UW = $clog2(PALETTE_DEPTH + 1);
  localparam int LW = $clog2(MAX_ROW_WIDTH + 1);

  logic [RGB_W-1:0] palette [PALETTE_DEPTH];
  logic [RGB_W-1:0] rdata;

  logic [RGB_W-1:0] rgb;
  logic             row_end;
  logic [UW-1:0]    used;
  logic             run_open;
  logic [IW-1:0]    run_idx;
  logic [LW-1:0]    run_len;
  logic [IW-1:0]    cl_idx;
  logic [LW-1:0]    cl_len;
  logic [IW-1:0]    ent_idx;
  logic [UW-1:0]    cnt;
  logic             rd_valid;
  logic [IW-1:0]    rd_addr;
  logic             p_close, p_entry, p_full, p_final;

  kind_t            o_kind;
  logic [IW-1:0]    o_idx;
  logic [RGB_W-1:0] o_rgb;
  logic [LW-1:0]    o_len;
  logic             o_last;

  logic             issue, hit, done;
  logic [IW-1:0]    idx;
  logic             full, is_new, same, close, fin;
  logic [LW-1:0]    len_next;
  logic             out_free;

  assign issue = (cnt < used);
  assign hit   = rd_valid && (rdata == rgb);
  assign done  = hit || (!rd_valid && !issue);

  // decision once the search ends
  assign full     = !hit && (used == UW'(PALETTE_DEPTH));
  assign idx      = hit ? rd_addr : used[IW-1:0];
  assign is_new   = !hit && !full;
  assign same     = run_open && (run_idx == idx);
  assign close    = !full && run_open && !same;
  assign len_next = same ? (run_len + 1'b1) : LW'(1);
  assign fin      = full ? (row_end && run_open)
                         : ((len_next >= LW'(MAX_ROW_WIDTH)) || row_end);

  assign out_free = !out_valid || out_ready;

  assign st.done     = done;
  assign st.pending  = p_close || p_entry || p_full || p_final;
  assign st.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.search && is_new && done) begin
      palette[used[IW-1:0]] <= rgb;
    end
    rdata <= palette[cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      run_open  <= 1'b0;
      run_idx   <= '0;
      run_len   <= '0;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      p_close   <= 1'b0;
      p_entry   <= 1'b0;
      p_full    <= 1'b0;
      p_final   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.accept) begin
        rgb      <= in_rgb;
        row_end  <= in_row_end;
        cnt      <= '0;
        rd_valid <= 1'b0;
        if (in_image_start) begin
          used <= '0;
          // run of the previous image goes out first
          if (run_open) begin
            p_close  <= 1'b1;
            cl_idx   <= run_idx;
            cl_len   <= run_len;
            run_open <= 1'b0;
            run_len  <= '0;
          end
        end
      end

      if (cmd.search) begin
        rd_valid <= issue;
        rd_addr  <= cnt[IW-1:0];
        if (issue) cnt <= cnt + 1'b1;
        if (done) begin
          if (close) begin
            p_close <= 1'b1;
            cl_idx  <= run_idx;
            cl_len  <= run_len;
          end
          p_entry <= is_new;
          p_full  <= full;
          p_final <= fin;
          ent_idx <= idx;
          if (is_new) used <= used + 1'b1;
          if (!full) begin
            run_open <= 1'b1;
            run_idx  <= idx;
            run_len  <= len_next;
          end
        end
      end

      if (cmd.emit) begin
        if (p_close) begin
          p_close <= 1'b0;
          o_kind  <= KIND_RUN;
          o_idx   <= cl_idx;
          o_rgb   <= '0;
          o_len   <= cl_len;
          o_last  <= !(p_entry || p_full || p_final);
        end else if (p_entry) begin
          p_entry <= 1'b0;
          o_kind  <= KIND_ENTRY;
          o_idx   <= ent_idx;
          o_rgb   <= rgb;
          o_len   <= '0;
          o_last  <= !(p_full || p_final);
        end else if (p_full) begin
          p_full  <= 1'b0;
          o_kind  <= KIND_FULL;
          o_idx   <= '0;
          o_rgb   <= '0;
          o_len   <= '0;
          o_last  <= !p_final;
        end else begin
          p_final  <= 1'b0;
          o_kind   <= KIND_RUN;
          o_idx    <= run_idx;
          o_rgb    <= '0;
          o_len    <= run_len;
          o_last   <= 1'b1;
          run_open <= 1'b0;
          run_len  <= '0;
        end
      end
    end
  end

  assign out_data = {{OUT_PAD_W{1'b0}}, CNT_OUT_W'(o_len), o_rgb[23:16], o_rgb[15:8],
                     o_rgb[7:0], IDX_OUT_W'(o_idx)};
  assign out_last = o_last;
  assign out_kind = o_kind;

endmodule

// ----- src/palette_rle_pixel_encoder.sv -----
// Channel  Dir  Word                                      Marks
// s_*      in   tdata: red, green, blue (24b)             tlast: row_end, tuser: image_start
// m_*      out  tdata: index, r, g, b, run_count (48b)    tlast: last, tuser: kind
// A pixel is accepted, then searched for through the palette memory read port,
// then its results are emitted in turn. No pixel is taken until every result
// of the previous one has moved into the output register. Results wait in one
// output register; m_tready low stalls emission.
// Synchronous reset clears run state and palette count; the palette memory
// itself is never cleared.
`include "palette_rle_pixel_encoder_macros.svh"

module palette_rle_pixel_encoder
  import prle_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic              s_tlast,
  input  logic              s_tuser,   // [0] image_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // [7:0] color_index, [15:8] out_red,
                                       // [23:16] out_green, [31:24] out_blue,
                                       // [44:32] run_count, [47:45] zero
  output logic              m_tlast,
  output logic [1:0]        m_tuser    // [1:0] kind
);

  cmd_t    cmd;
  status_t st;

  prle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  prle_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .in_rgb         (s_tdata),
    .in_row_end     (s_tlast),
    .in_image_start (s_tuser),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_data       (m_tdata),
    .out_last       (m_tlast),
    .out_kind       (m_tuser)
  );

  `PRLE_ASSERT_NOW(a_ready_no_pending, s_tready, !st.pending, "input ready with results pending")
  `PRLE_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")
  `PRLE_ASSERT_NOW(a_full_zero, m_tvalid && (m_tuser == KIND_FULL), m_tdata == '0, "full word not zero")
  `PRLE_ASSERT_NOW(a_entry_no_count, m_tvalid && (m_tuser == KIND_ENTRY), m_tdata[44:32] == '0, "entry with count")

endmodule
